// ===== design/fpsa_pkg.sv =====
// Shared types, codes and constants of the fit policy segment allocator.
// Used by fpsa_cell, fpsa_cell_row and fit_policy_segment_allocator_core.
package fpsa_pkg;

    localparam int ADDR_BITS     = 16;
    localparam int OWNER_BITS    = 8;
    localparam int COUNT_BITS    = 7;
    localparam int KIND_BITS     = 2;
    localparam int STATUS_BITS   = 2;
    localparam int POLICY_BITS   = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int MAP_ENTRIES_DEFAULT = 64;
    localparam logic [ADDR_BITS-1:0] RESET_MEM_SIZE = 16'd1024;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ALLOC     = 2'd0,
        KIND_RELEASE   = 2'd1,
        KIND_MAP_RESET = 2'd2
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [POLICY_BITS-1:0] {
        POL_BEST  = 2'd0,
        POL_FIRST = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIT_POLICY  = 1'd0,
        CFG_MEMORY_SIZE = 1'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_WRITE,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN
    } cell_op_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  base;
        logic [ADDR_BITS-1:0]  last;
        logic [ADDR_BITS-1:0]  size;
        logic [OWNER_BITS-1:0] owner;
    } seg_t;

    typedef struct packed {
        cell_op_t op;
        seg_t     data;
    } cell_cmd_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [ADDR_BITS-1:0]  alloc_size;
        logic [OWNER_BITS-1:0] owner_id;
        logic [ADDR_BITS-1:0]  resume_address;
        logic [ADDR_BITS-1:0]  block_start;
        logic [ADDR_BITS-1:0]  block_end;
    } req_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   seg_start;
        logic [ADDR_BITS-1:0]   seg_end;
        logic [ADDR_BITS-1:0]   seg_size;
        logic [OWNER_BITS-1:0]  seg_owner;
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  segment_count;
    } res_t;

    localparam seg_t SEG_ZERO = '0;
    localparam seg_t SEG_RESET = '{base: '0, last: RESET_MEM_SIZE - 16'd1,
                                   size: RESET_MEM_SIZE, owner: '0};

endpackage

// ===== design/fpsa_cell.sv =====
// One map entry of the segment ring: holds a segment, trades it with neighbors.
// Depends on fpsa_pkg.
module fpsa_cell #(
    parameter int            N    = fpsa_pkg::MAP_ENTRIES_DEFAULT,
    parameter int            IDX  = 0,
    parameter fpsa_pkg::seg_t INIT = fpsa_pkg::SEG_ZERO
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fpsa_pkg::cell_cmd_t      cmd,
    input  logic [$clog2(N)-1:0]     addr,
    input  fpsa_pkg::seg_t           left,
    input  fpsa_pkg::seg_t           right,
    output fpsa_pkg::seg_t           q
);
    localparam int IW = $clog2(N);
    localparam logic [IW-1:0] ME = IW'(IDX);

    fpsa_pkg::seg_t seg_reg;
    fpsa_pkg::seg_t seg_next;

    always_comb
    begin
        seg_next = seg_reg;
        case (cmd.op)
            fpsa_pkg::OP_ROTATE:
            begin
                seg_next = right;
            end
            fpsa_pkg::OP_WRITE:
            begin
                if (ME == addr)
                begin
                    seg_next = cmd.data;
                end
            end
            fpsa_pkg::OP_SHIFT_UP:
            begin
                if (ME > addr)
                begin
                    seg_next = left;
                end
                else if (ME == addr)
                begin
                    seg_next = cmd.data;
                end
            end
            fpsa_pkg::OP_SHIFT_DOWN:
            begin
                if (ME >= addr)
                begin
                    seg_next = right;
                end
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= INIT;
        end
        else
        begin
            seg_reg <= seg_next;
        end
    end

    assign q = seg_reg;

endmodule

// ===== design/fpsa_cell_row.sv =====
// Ring of N segment cells; cell 0 is the head seen by the scan.
// Depends on fpsa_pkg and fpsa_cell.
module fpsa_cell_row #(
    parameter int N = fpsa_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpsa_pkg::cell_cmd_t  cmd,
    input  logic [$clog2(N)-1:0] addr,
    output fpsa_pkg::seg_t       head
);
    fpsa_pkg::seg_t ring [N];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        fpsa_cell #(
            .N    (N),
            .IDX  (k),
            .INIT ((k == 0) ? fpsa_pkg::SEG_RESET : fpsa_pkg::SEG_ZERO)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .addr  (addr),
            .left  (ring[(k + N - 1) % N]),
            .right (ring[(k + 1) % N]),
            .q     (ring[k])
        );
    end

    assign head = ring[0];

endmodule

// ===== design/fit_policy_segment_allocator_core.sv =====
// Top level of the fit policy segment allocator: control sequencer and config.
// Depends on fpsa_pkg and fpsa_cell_row.
//
// Keeps an address-ordered map of up to MAP_ENTRIES segments in a ring of
// cells. A request is taken when start is high and busy is low; its single
// result appears on result for exactly one cycle with done high, and the
// receiver cannot stall it. Allocate and release requests rotate the whole
// ring once past the head cell and then edit the map in the apply state,
// plus the finish state for a split or once per merged neighbor on release.
// A map reset skips the scan and goes straight to the apply state. A
// zero-size allocate or an unknown kind raises done in the very next cycle
// after it is taken. A new request may be started in the same cycle done is
// high. Config writes (wr_en, wr_index, wr_data) go straight into the
// registers; that they are only used by later requests is up to the user, as
// the block does not enforce it; the memory size takes effect at the next map reset.
module fit_policy_segment_allocator_core #(
    parameter int MAP_ENTRIES = fpsa_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  fpsa_pkg::req_t                        request,
    output logic                                  done,
    output fpsa_pkg::res_t                        result,
    input  logic                                  wr_en,
    input  logic [fpsa_pkg::CFG_IDX_BITS-1:0]     wr_index,
    input  logic [fpsa_pkg::ADDR_BITS-1:0]        wr_data
);
    localparam int N  = MAP_ENTRIES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int AB = fpsa_pkg::ADDR_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(N);

    fpsa_pkg::state_t  state_reg, state_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     n_reg, n_next;
    fpsa_pkg::req_t    req_reg, req_next;
    logic [1:0]        policy_reg, policy_next;
    logic [AB-1:0]     msize_reg, msize_next;

    // allocation picks: pk = best/worst/first, or next fit's wrapped part
    logic              pk_v_reg, pk_v_next;
    logic [IW-1:0]     pk_idx_reg, pk_idx_next;
    fpsa_pkg::seg_t    pk_seg_reg, pk_seg_next;
    logic              hi_v_reg, hi_v_next;
    logic [IW-1:0]     hi_idx_reg, hi_idx_next;
    fpsa_pkg::seg_t    hi_seg_reg, hi_seg_next;
    logic              from_reg, from_next;

    // release capture
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    fpsa_pkg::seg_t    ent_reg, ent_next;
    fpsa_pkg::seg_t    prev_reg, prev_next;
    logic              lfree_reg, lfree_next;
    fpsa_pkg::seg_t    lseg_reg, lseg_next;
    logic              rfree_reg, rfree_next;
    fpsa_pkg::seg_t    rseg_reg, rseg_next;
    logic              need_r_reg, need_r_next;
    logic [1:0]        rem_reg, rem_next;
    logic [IW-1:0]     a_reg, a_next;

    logic              done_reg, done_next;
    fpsa_pkg::res_t    res_reg, res_next;

    fpsa_pkg::cell_cmd_t cmd;
    logic [IW-1:0]       addr;
    fpsa_pkg::seg_t      head;

    // selection after the scan
    logic              sel_v;
    logic [IW-1:0]     sel_idx;
    fpsa_pkg::seg_t    sel_seg;
    logic              split;
    logic [1:0]        rem_cnt;
    logic [IW-1:0]     first_idx;
    fpsa_pkg::seg_t    merged;

    // scan-time head tests
    logic              head_valid;
    logic              head_fits;
    logic              head_resume;

    fpsa_cell_row #(.N(N)) u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .addr  (addr),
        .head  (head)
    );

    assign head_valid  = CW'(cnt_reg) < n_reg;
    assign head_fits   = head_valid && (head.owner == '0) &&
                         (head.size >= req_reg.alloc_size);
    assign head_resume = head_valid && (head.base == req_reg.resume_address);

    assign sel_v   = (policy_reg == fpsa_pkg::POL_NEXT) ? (hi_v_reg || pk_v_reg) : pk_v_reg;
    assign sel_idx = (policy_reg == fpsa_pkg::POL_NEXT && hi_v_reg) ? hi_idx_reg : pk_idx_reg;
    assign sel_seg = (policy_reg == fpsa_pkg::POL_NEXT && hi_v_reg) ? hi_seg_reg : pk_seg_reg;
    assign split   = sel_seg.size > req_reg.alloc_size;

    assign rem_cnt   = {1'b0, lfree_reg} + {1'b0, rfree_reg};
    assign first_idx = lfree_reg ? (hit_idx_reg - IW'(1)) : hit_idx_reg;
    assign merged.base  = lfree_reg ? lseg_reg.base : ent_reg.base;
    assign merged.last  = rfree_reg ? rseg_reg.last : ent_reg.last;
    assign merged.size  = ent_reg.size + (lfree_reg ? lseg_reg.size : '0) +
                          (rfree_reg ? rseg_reg.size : '0);
    assign merged.owner = '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (request.kind)
                        fpsa_pkg::KIND_ALLOC:
                            state_next = (request.alloc_size == '0) ?
                                         fpsa_pkg::S_IDLE : fpsa_pkg::S_SCAN;
                        fpsa_pkg::KIND_RELEASE:   state_next = fpsa_pkg::S_SCAN;
                        fpsa_pkg::KIND_MAP_RESET: state_next = fpsa_pkg::S_APPLY;
                        default:                  state_next = fpsa_pkg::S_IDLE;
                    endcase
                end
            end
            fpsa_pkg::S_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = fpsa_pkg::S_APPLY;
                end
            end
            fpsa_pkg::S_APPLY:
            begin
                state_next = fpsa_pkg::S_IDLE;
                if (req_reg.kind == fpsa_pkg::KIND_ALLOC && sel_v && split &&
                    n_reg < FULL_CNT)
                begin
                    state_next = fpsa_pkg::S_FINISH;
                end
                else if (req_reg.kind == fpsa_pkg::KIND_RELEASE && hit_reg &&
                         rem_cnt != 2'd0)
                begin
                    state_next = fpsa_pkg::S_FINISH;
                end
            end
            fpsa_pkg::S_FINISH:
            begin
                if (req_reg.kind != fpsa_pkg::KIND_RELEASE || rem_reg == 2'd1)
                begin
                    state_next = fpsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpsa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and cell commands
    always_comb
    begin
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        req_next    = req_reg;
        policy_next = policy_reg;
        msize_next  = msize_reg;
        pk_v_next   = pk_v_reg;
        pk_idx_next = pk_idx_reg;
        pk_seg_next = pk_seg_reg;
        hi_v_next   = hi_v_reg;
        hi_idx_next = hi_idx_reg;
        hi_seg_next = hi_seg_reg;
        from_next   = from_reg;
        hit_next    = hit_reg;
        hit_idx_next = hit_idx_reg;
        ent_next    = ent_reg;
        prev_next   = prev_reg;
        lfree_next  = lfree_reg;
        lseg_next   = lseg_reg;
        rfree_next  = rfree_reg;
        rseg_next   = rseg_reg;
        need_r_next = need_r_reg;
        rem_next    = rem_reg;
        a_next      = a_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        cmd.op      = fpsa_pkg::OP_HOLD;
        cmd.data    = sel_seg;
        addr        = sel_idx;

        if (wr_en)
        begin
            case (wr_index)
                fpsa_pkg::CFG_FIT_POLICY:  policy_next = wr_data[fpsa_pkg::POLICY_BITS-1:0];
                fpsa_pkg::CFG_MEMORY_SIZE: msize_next  = wr_data;
                default:                   policy_next = policy_reg;
            endcase
        end

        case (state_reg)
            fpsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    cnt_next   = '0;
                    pk_v_next  = 1'b0;
                    hi_v_next  = 1'b0;
                    from_next  = 1'b0;
                    hit_next   = 1'b0;
                    lfree_next = 1'b0;
                    rfree_next = 1'b0;
                    need_r_next = 1'b0;
                    res_next   = '0;
                    if (request.kind == fpsa_pkg::KIND_ALLOC && request.alloc_size == '0)
                    begin
                        done_next = 1'b1;
                        res_next.status = fpsa_pkg::ST_NO_FIT;
                    end
                    else if (request.kind != fpsa_pkg::KIND_ALLOC &&
                             request.kind != fpsa_pkg::KIND_RELEASE &&
                             request.kind != fpsa_pkg::KIND_MAP_RESET)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            fpsa_pkg::S_SCAN:
            begin
                cmd.op    = fpsa_pkg::OP_ROTATE;
                cnt_next  = cnt_reg + IW'(1);
                prev_next = head;
                if (req_reg.kind == fpsa_pkg::KIND_ALLOC)
                begin
                    case (policy_reg) inside
                        fpsa_pkg::POL_BEST, fpsa_pkg::POL_WORST:
                        begin
                            if (head_fits && (!pk_v_reg ||
                                (policy_reg == fpsa_pkg::POL_BEST &&
                                 head.size < pk_seg_reg.size) ||
                                (policy_reg == fpsa_pkg::POL_WORST &&
                                 head.size > pk_seg_reg.size)))
                            begin
                                pk_v_next   = 1'b1;
                                pk_idx_next = cnt_reg;
                                pk_seg_next = head;
                            end
                        end
                        fpsa_pkg::POL_FIRST:
                        begin
                            if (head_fits && !pk_v_reg)
                            begin
                                pk_v_next   = 1'b1;
                                pk_idx_next = cnt_reg;
                                pk_seg_next = head;
                            end
                        end
                        default:
                        begin
                            // next fit: hi from the resume segment on, pk before it
                            if (head_resume)
                            begin
                                from_next = 1'b1;
                            end
                            if (head_fits && (from_reg || head_resume) && !hi_v_reg)
                            begin
                                hi_v_next   = 1'b1;
                                hi_idx_next = cnt_reg;
                                hi_seg_next = head;
                            end
                            if (head_fits && !from_reg && !head_resume && !pk_v_reg)
                            begin
                                pk_v_next   = 1'b1;
                                pk_idx_next = cnt_reg;
                                pk_seg_next = head;
                            end
                        end
                    endcase
                end
                else
                begin
                    need_r_next = 1'b0;
                    if (need_r_reg)
                    begin
                        rfree_next = head_valid && (head.owner == '0);
                        rseg_next  = head;
                    end
                    if (!hit_reg && head_valid && head.base == req_reg.block_start &&
                        head.last == req_reg.block_end)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cnt_reg;
                        ent_next     = head;
                        lfree_next   = (cnt_reg != '0) && (prev_reg.owner == '0);
                        lseg_next    = prev_reg;
                        need_r_next  = 1'b1;
                    end
                end
            end
            fpsa_pkg::S_APPLY:
            begin
                case (req_reg.kind)
                    fpsa_pkg::KIND_ALLOC:
                    begin
                        res_next = '0;
                        if (!sel_v)
                        begin
                            done_next = 1'b1;
                            res_next.status = fpsa_pkg::ST_NO_FIT;
                        end
                        else if (split && n_reg >= FULL_CNT)
                        begin
                            done_next = 1'b1;
                            res_next.status = fpsa_pkg::ST_FULL;
                        end
                        else if (split)
                        begin
                            // remainder goes right after the granted segment
                            cmd.op         = fpsa_pkg::OP_SHIFT_UP;
                            addr           = sel_idx + IW'(1);
                            cmd.data.base  = sel_seg.base + req_reg.alloc_size;
                            cmd.data.last  = sel_seg.last;
                            cmd.data.size  = sel_seg.size - req_reg.alloc_size;
                            cmd.data.owner = '0;
                            n_next         = n_reg + CW'(1);
                        end
                        else
                        begin
                            cmd.op          = fpsa_pkg::OP_WRITE;
                            cmd.data.owner  = req_reg.owner_id;
                            done_next       = 1'b1;
                            res_next.seg_start = sel_seg.base;
                            res_next.seg_end   = sel_seg.last;
                            res_next.seg_size  = sel_seg.size;
                            res_next.seg_owner = req_reg.owner_id;
                        end
                    end
                    fpsa_pkg::KIND_RELEASE:
                    begin
                        res_next = '0;
                        if (!hit_reg)
                        begin
                            done_next = 1'b1;
                            res_next.status = fpsa_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.op   = fpsa_pkg::OP_WRITE;
                            cmd.data = merged;
                            addr     = first_idx;
                            a_next   = first_idx + IW'(1);
                            rem_next = rem_cnt;
                            res_next.seg_start = merged.base;
                            res_next.seg_end   = merged.last;
                            res_next.seg_size  = merged.size;
                            done_next = (rem_cnt == 2'd0);
                        end
                    end
                    default:
                    begin
                        cmd.op        = fpsa_pkg::OP_WRITE;
                        addr          = '0;
                        cmd.data.base = '0;
                        cmd.data.last = msize_reg - AB'(1);
                        cmd.data.size = msize_reg;
                        cmd.data.owner = '0;
                        n_next        = CW'(1);
                        done_next     = 1'b1;
                        res_next      = '0;
                        res_next.seg_end  = msize_reg - AB'(1);
                        res_next.seg_size = msize_reg;
                    end
                endcase
            end
            fpsa_pkg::S_FINISH:
            begin
                if (req_reg.kind == fpsa_pkg::KIND_RELEASE)
                begin
                    cmd.op    = fpsa_pkg::OP_SHIFT_DOWN;
                    addr      = a_reg;
                    rem_next  = rem_reg - 2'd1;
                    n_next    = n_reg - CW'(1);
                    done_next = (rem_reg == 2'd1);
                end
                else
                begin
                    cmd.op         = fpsa_pkg::OP_WRITE;
                    cmd.data.base  = sel_seg.base;
                    cmd.data.last  = sel_seg.base + req_reg.alloc_size - AB'(1);
                    cmd.data.size  = req_reg.alloc_size;
                    cmd.data.owner = req_reg.owner_id;
                    done_next      = 1'b1;
                    res_next.seg_start = sel_seg.base;
                    res_next.seg_end   = sel_seg.base + req_reg.alloc_size - AB'(1);
                    res_next.seg_size  = req_reg.alloc_size;
                    res_next.seg_owner = req_reg.owner_id;
                    res_next.status    = fpsa_pkg::ST_OK;
                end
            end
            default:
            begin
                cmd.op = fpsa_pkg::OP_HOLD;
            end
        endcase

        if (done_next)
        begin
            res_next.segment_count = fpsa_pkg::COUNT_BITS'(n_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fpsa_pkg::S_IDLE;
            cnt_reg    <= '0;
            n_reg      <= CW'(1);
            policy_reg <= fpsa_pkg::POL_BEST;
            msize_reg  <= fpsa_pkg::RESET_MEM_SIZE;
            pk_v_reg   <= 1'b0;
            hi_v_reg   <= 1'b0;
            from_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            lfree_reg  <= 1'b0;
            rfree_reg  <= 1'b0;
            need_r_reg <= 1'b0;
            rem_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            policy_reg <= policy_next;
            msize_reg  <= msize_next;
            pk_v_reg   <= pk_v_next;
            hi_v_reg   <= hi_v_next;
            from_reg   <= from_next;
            hit_reg    <= hit_next;
            lfree_reg  <= lfree_next;
            rfree_reg  <= rfree_next;
            need_r_reg <= need_r_next;
            rem_reg    <= rem_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        pk_idx_reg  <= pk_idx_next;
        pk_seg_reg  <= pk_seg_next;
        hi_idx_reg  <= hi_idx_next;
        hi_seg_reg  <= hi_seg_next;
        hit_idx_reg <= hit_idx_next;
        ent_reg     <= ent_next;
        prev_reg    <= prev_next;
        lseg_reg    <= lseg_next;
        rseg_reg    <= rseg_next;
        a_reg       <= a_next;
        res_reg     <= res_next;
    end

    assign busy   = (state_reg != fpsa_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // map never holds more than its entries, nor fewer than one segment
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg <= FULL_CNT) && (n_reg != '0))
        else $error("segment count out of range");

    // a failed request reports an empty segment
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != fpsa_pkg::ST_OK |->
        result.seg_start == '0 && result.seg_size == '0 && result.seg_owner == '0)
        else $error("failure result carries segment data");

    // the scan always runs a full ring turn before edits
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpsa_pkg::S_SCAN && state_next == fpsa_pkg::S_APPLY |->
        cnt_reg == LAST_IDX)
        else $error("scan left early");

    // a split grows the map by exactly one entry
    a_split_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpsa_pkg::S_APPLY && state_next == fpsa_pkg::S_FINISH &&
        req_reg.kind == fpsa_pkg::KIND_ALLOC |=> n_reg == $past(n_reg) + CW'(1))
        else $error("split did not add a segment");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for fit_policy_segment_allocator_core.
// Depends on fpsa_pkg and the allocator RTL; predicts each result from a
// private copy of the segment map and checks it in order of arrival.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = fpsa_pkg::MAP_ENTRIES_DEFAULT;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [fpsa_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    // Scoreboard: in-order queue of predicted results, mismatch reporting.
    class alloc_scoreboard;
        fpsa_pkg::res_t pending[$];
        int   errors;

        function void note_request(fpsa_pkg::res_t predicted);
            pending.push_back(predicted);
        endfunction

        function void check_result(fpsa_pkg::res_t actual);
            fpsa_pkg::res_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", actual);
                return;
            end
            want = pending.pop_front();
            if (want !== actual)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p actual %p", want, actual);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    fpsa_pkg::req_t request = '0;
    logic done;
    fpsa_pkg::res_t result;
    logic wr_en = 1'b0;
    logic [fpsa_pkg::CFG_IDX_BITS-1:0] wr_index = '0;
    logic [fpsa_pkg::ADDR_BITS-1:0] wr_data = '0;

    fit_policy_segment_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    alloc_scoreboard board = new();

    // Predictor state: policy, memory size and the segment map.
    fpsa_pkg::policy_t pol_q;
    logic [15:0]       msize_q;
    fpsa_pkg::seg_t    segmap[ENTRIES];
    int                nseg;

    bit   idle_on = 1'b1;
    int   quiet_cycles = 0;

    function automatic void map_rebuild();
        for (int i = 0; i < ENTRIES; i++)
            segmap[i] = fpsa_pkg::SEG_ZERO;
        segmap[0].size = msize_q;
        segmap[0].last = msize_q - 16'd1;
        nseg = 1;
    endfunction

    function automatic fpsa_pkg::res_t fail_res(fpsa_pkg::status_t st);
        fpsa_pkg::res_t r;
        r = '0;
        r.status = st;
        r.segment_count = nseg[6:0];
        return r;
    endfunction

    function automatic bit is_free_fit(int i, logic [15:0] need);
        return segmap[i].owner == '0 && segmap[i].size >= need;
    endfunction

    function automatic int pick_segment(logic [15:0] need, logic [15:0] resume);
        int pick;
        int from;
        pick = -1;
        from = 0;
        case (pol_q) inside
            fpsa_pkg::POL_BEST, fpsa_pkg::POL_WORST:
            begin
                for (int i = 0; i < nseg; i++)
                    if (is_free_fit(i, need))
                        if (pick < 0
                            || (pol_q == fpsa_pkg::POL_BEST
                                && segmap[i].size < segmap[pick].size)
                            || (pol_q == fpsa_pkg::POL_WORST
                                && segmap[i].size > segmap[pick].size))
                            pick = i;
            end
            fpsa_pkg::POL_FIRST:
            begin
                for (int i = 0; i < nseg && pick < 0; i++)
                    if (is_free_fit(i, need))
                        pick = i;
            end
            default:
            begin
                for (int i = nseg - 1; i >= 0; i--)
                    if (segmap[i].base == resume)
                        from = i;
                for (int i = from; i < nseg && pick < 0; i++)
                    if (is_free_fit(i, need))
                        pick = i;
                for (int i = 0; i < from && pick < 0; i++)
                    if (is_free_fit(i, need))
                        pick = i;
            end
        endcase
        return pick;
    endfunction

    function automatic fpsa_pkg::res_t predict_allocate(fpsa_pkg::req_t rq);
        int b;
        fpsa_pkg::res_t r;
        if (rq.alloc_size == 0)
            return fail_res(fpsa_pkg::ST_NO_FIT);
        b = pick_segment(rq.alloc_size, rq.resume_address);
        if (b < 0)
            return fail_res(fpsa_pkg::ST_NO_FIT);
        if (segmap[b].size > rq.alloc_size)
        begin
            if (nseg >= ENTRIES)
                return fail_res(fpsa_pkg::ST_FULL);
            for (int k = nseg; k > b + 1; k--)
                segmap[k] = segmap[k-1];
            segmap[b+1].base = segmap[b].base + rq.alloc_size;
            segmap[b+1].last = segmap[b].last;
            segmap[b+1].size = segmap[b].size - rq.alloc_size;
            segmap[b+1].owner = '0;
            segmap[b].size = rq.alloc_size;
            segmap[b].last = segmap[b].base + rq.alloc_size - 16'd1;
            nseg++;
        end
        segmap[b].owner = rq.owner_id;
        r.seg_start = segmap[b].base;
        r.seg_end = segmap[b].last;
        r.seg_size = segmap[b].size;
        r.seg_owner = rq.owner_id;
        r.status = fpsa_pkg::ST_OK;
        r.segment_count = nseg[6:0];
        return r;
    endfunction

    function automatic fpsa_pkg::res_t predict_release(fpsa_pkg::req_t rq);
        int idx;
        int first;
        int gone;
        fpsa_pkg::seg_t m;
        fpsa_pkg::res_t r;
        idx = -1;
        for (int i = nseg - 1; i >= 0; i--)
            if (segmap[i].base == rq.block_start && segmap[i].last == rq.block_end)
                idx = i;
        if (idx < 0)
            return fail_res(fpsa_pkg::ST_NOT_FOUND);
        first = idx;
        gone = 0;
        m = segmap[idx];
        if (idx > 0 && segmap[idx-1].owner == '0)
        begin
            first = idx - 1;
            m.base = segmap[first].base;
            m.size += segmap[first].size;
            gone++;
        end
        if (idx + 1 < nseg && segmap[idx+1].owner == '0)
        begin
            m.last = segmap[idx+1].last;
            m.size += segmap[idx+1].size;
            gone++;
        end
        m.owner = '0;
        segmap[first] = m;
        for (int k = first + 1; k + gone < nseg; k++)
            segmap[k] = segmap[k+gone];
        nseg -= gone;
        r.seg_start = m.base;
        r.seg_end = m.last;
        r.seg_size = m.size;
        r.seg_owner = '0;
        r.status = fpsa_pkg::ST_OK;
        r.segment_count = nseg[6:0];
        return r;
    endfunction

    function automatic fpsa_pkg::res_t predict_request(fpsa_pkg::req_t rq);
        fpsa_pkg::res_t r;
        case (rq.kind)
            fpsa_pkg::KIND_ALLOC:   r = predict_allocate(rq);
            fpsa_pkg::KIND_RELEASE: r = predict_release(rq);
            fpsa_pkg::KIND_MAP_RESET:
            begin
                map_rebuild();
                r.seg_start = segmap[0].base;
                r.seg_end = segmap[0].last;
                r.seg_size = segmap[0].size;
                r.seg_owner = '0;
                r.status = fpsa_pkg::ST_OK;
                r.segment_count = 7'd1;
            end
            default: r = fail_res(fpsa_pkg::ST_OK);
        endcase
        return r;
    endfunction

    // Results are sampled at the edge that ends the strobe cycle.
    always @(posedge clk)
        if (rst_n && done)
            board.check_result(result);

    // Watchdog: cycles with neither a request nor a result taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL fit_policy_segment_allocator_core");
            $finish;
        end
    end

    // Issue one request, idling first at random, and hold until accepted.
    // start stays high after acceptance; the next call or stop_requests
    // drives it in the same time step.
    task automatic send_request(fpsa_pkg::req_t rq);
        if (idle_on && $urandom_range(99) < 33)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 33)
                @(posedge clk);
        end
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(predict_request(rq));
    endtask

    task automatic stop_requests();
        start <= 1'b0;
    endtask

    // Register write, only while nothing is outstanding.
    task automatic write_reg(fpsa_pkg::cfg_index_t idx, logic [15:0] val);
        stop_requests();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == fpsa_pkg::CFG_FIT_POLICY)
            pol_q = fpsa_pkg::policy_t'(val[1:0]);
        else
            msize_q = val;
    endtask

    // Every field random; the makers below overwrite what they need.
    function automatic fpsa_pkg::req_t random_fields();
        fpsa_pkg::req_t rq;
        rq.kind = 2'($urandom);
        rq.alloc_size = 16'($urandom);
        rq.owner_id = 8'($urandom);
        rq.resume_address = 16'($urandom);
        rq.block_start = 16'($urandom);
        rq.block_end = 16'($urandom);
        return rq;
    endfunction

    function automatic fpsa_pkg::req_t make_alloc(logic [15:0] sz, logic [7:0] own,
                                                  logic [15:0] resume);
        fpsa_pkg::req_t rq;
        rq = random_fields();
        rq.kind = fpsa_pkg::KIND_ALLOC;
        rq.alloc_size = sz;
        rq.owner_id = own;
        rq.resume_address = resume;
        return rq;
    endfunction

    function automatic fpsa_pkg::req_t make_release(logic [15:0] bs, logic [15:0] be);
        fpsa_pkg::req_t rq;
        rq = random_fields();
        rq.kind = fpsa_pkg::KIND_RELEASE;
        rq.block_start = bs;
        rq.block_end = be;
        return rq;
    endfunction

    function automatic fpsa_pkg::req_t make_map_reset();
        fpsa_pkg::req_t rq;
        rq = random_fields();
        rq.kind = fpsa_pkg::KIND_MAP_RESET;
        return rq;
    endfunction

    // Random request biased toward live segments so the map gets deep.
    function automatic fpsa_pkg::req_t random_request();
        int roll;
        int i;
        logic [15:0] sz;
        fpsa_pkg::req_t rq;
        roll = $urandom_range(99);
        i = $urandom_range(nseg - 1);
        if (roll < 50)
        begin
            case ($urandom_range(3))
                0: sz = 16'($urandom_range(64, 1));
                1: sz = 16'($urandom_range(msize_q > 0 ? msize_q : 1, 1));
                2: sz = 16'($urandom);
                default: sz = 16'($urandom_range(8, 0));
            endcase
            return make_alloc(sz, 8'($urandom),
                              $urandom_range(1) ? segmap[i].base : 16'($urandom));
        end
        if (roll < 88)
            return make_release(segmap[i].base, segmap[i].last);
        if (roll < 95)
            return make_release(16'($urandom), 16'($urandom));
        if (roll < 98)
        begin
            rq = random_fields();
            rq.kind = KIND_UNUSED;
            return rq;
        end
        return make_map_reset();
    endfunction

    initial
    begin
        pol_q = fpsa_pkg::POL_BEST;
        msize_q = fpsa_pkg::RESET_MEM_SIZE;
        map_rebuild();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every kind, zero size, owner zero, not found, free release,
        // full map, size extremes and the unknown kind.
        send_request(make_alloc(16'd0, 8'd5, 16'd0));
        send_request(make_alloc(16'd100, 8'd1, 16'd0));
        send_request(make_alloc(16'd200, 8'd0, 16'd0));
        send_request(make_alloc(16'd2000, 8'd255, 16'd0));
        send_request(make_release(16'd100, 16'd299));
        send_request(make_release(16'd300, 16'd1023));
        send_request(make_release(16'd7, 16'd9));
        send_request(make_release(16'd0, 16'd99));
        begin
            fpsa_pkg::req_t odd;
            odd = '1;
            send_request(odd);
        end
        write_reg(fpsa_pkg::CFG_FIT_POLICY, 16'(fpsa_pkg::POL_NEXT));
        write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'd0);
        send_request(make_map_reset());
        send_request(make_alloc(16'hFFFF, 8'd3, 16'hFFFF));
        write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'hFFFF);
        send_request(make_map_reset());
        for (int k = 0; k < 64; k++)
            send_request(make_alloc(16'd1, 8'($urandom_range(255, 1)), 16'd0));
        send_request(make_alloc(16'd1, 8'd9, 16'd40));
        write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'd1);
        send_request(make_map_reset());
        send_request(make_alloc(16'd1, 8'd2, 16'd0));

        // Random phases with a random policy each and several memory sizes.
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(fpsa_pkg::CFG_FIT_POLICY, 16'($urandom_range(3)));
            case (ph % 4)
                0: write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'd1024);
                1: write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'($urandom));
                2: write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'hFFFF);
                default: write_reg(fpsa_pkg::CFG_MEMORY_SIZE, 16'($urandom_range(200, 1)));
            endcase
            send_request(make_map_reset());
            idle_on = (ph != 5);
            for (int k = 0; k < 100; k++)
                send_request(random_request());
        end

        stop_requests();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (board.errors == 0)
            $display("PASS fit_policy_segment_allocator_core");
        else
            $display("FAIL fit_policy_segment_allocator_core");
        $finish;
    end

    // A leftover expectation at the end is caught by the pending wait above
    // via the watchdog; extra results are caught in check_result.
endmodule

// ===== filelist.f =====
design/fpsa_pkg.sv
design/fpsa_cell.sv
design/fpsa_cell_row.sv
design/fit_policy_segment_allocator_core.sv
test/testbench.sv
